[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertions with active-low reset masking.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define LMSS_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define LMSS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  `LMSS_ASSERT(lbl, clk_s, rstn_s, (ante) |=> (cons), msg)

`endif

[rtl/lmss_pkg.sv]
// ----------------------------------------------------------------------------
// lmss_pkg
// Types, constants and duration lookup for the LCD mode scanline sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lmss_pkg;

  localparam int CNT_W   = 10;
  localparam int LINE_W  = 8;
  localparam int ELAP_W  = 5;
  localparam int CMP_W   = 8;
  localparam int IRQ_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int N_STEPS = 4;

  localparam logic [CNT_W-1:0] DUR_HBLANK = 10'd204;
  localparam logic [CNT_W-1:0] DUR_VBLANK = 10'd456;
  localparam logic [CNT_W-1:0] DUR_OAM    = 10'd80;
  localparam logic [CNT_W-1:0] DUR_XFER   = 10'd172;

  localparam logic [CNT_W-1:0] CREDIT_SGL = 10'd4;
  localparam logic [CNT_W-1:0] CREDIT_DBL = 10'd8;

  localparam logic [LINE_W-1:0] FIRST_BLANK_LINE = 8'd144;
  localparam logic [LINE_W-1:0] WRAP_LINE        = 8'd153;

  localparam int EN_HBLANK_BIT = 0;
  localparam int EN_VBLANK_BIT = 1;
  localparam int EN_OAM_BIT    = 2;
  localparam int EN_MATCH_BIT  = 3;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LCD_ENABLE   = 2'd0,
    CFG_LINE_COMPARE = 2'd1,
    CFG_IRQ_ENABLES  = 2'd2,
    CFG_DOUBLE_SPEED = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CMP_W-1:0]  compare;
    logic [IRQ_W-1:0]  irq_en;
    logic              dbl;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    mode_t             mode;
    logic [LINE_W-1:0] line;
    logic              match;
  } lcd_state_t;

  typedef struct packed {
    logic vblank;
    logic stat;
    logic draw;
  } pulse_t;

  typedef struct packed {
    logic [LINE_W-1:0] line;
    mode_t             mode;
    logic              match;
    pulse_t            pulse;
  } result_t;

  function automatic logic [CNT_W-1:0] mode_dur(input mode_t mode, input logic dbl);
    logic [CNT_W-1:0] base;
    case (mode)
      MODE_HBLANK: base = DUR_HBLANK;
      MODE_VBLANK: base = DUR_VBLANK;
      MODE_OAM:    base = DUR_OAM;
      MODE_XFER:   base = DUR_XFER;
      default:     base = DUR_HBLANK;
    endcase
    return dbl ? {base[CNT_W-2:0], 1'b0} : base;
  endfunction

endpackage

`default_nettype wire

[rtl/lcd_mode_scanline_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// lcd_mode_scanline_sequencer_unit
// LCD mode and scanline timing sequencer with valid/stall channels.
// ----------------------------------------------------------------------------
// Each item carries the CPU time elapsed since the previous one and yields
// exactly one result: the line, the display mode, the coincidence flag and the
// vblank, status and draw pulses. An item is registered on entry and settled
// by a chain of four transition units as it moves from the entry register
// into the output register, so the block takes one item per cycle while the
// output side does not stall, and the result waits in the output register
// until it is taken. The output register frees itself in the same cycle its
// item is taken, keeping the throughput at one item per cycle.
// Write configuration only while no item is in flight.
`default_nettype none
`include "assert_macros.svh"

module lcd_mode_scanline_sequencer_unit (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire [lmss_pkg::ELAP_W-1:0]      in_elapsed_cycles,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic [lmss_pkg::LINE_W-1:0]     out_line,
  output logic [1:0]                      out_lcd_mode,
  output logic                            out_coincidence,
  output logic                            out_vblank_irq,
  output logic                            out_stat_irq,
  output logic                            out_draw_line,
  input  wire                             cfg_we,
  input  wire [lmss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [lmss_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic                        s1_vld_r, s1_vld_nxt;
  logic [lmss_pkg::ELAP_W-1:0] s1_elapsed_r;
  logic                        s1_adv;
  logic                        out_vld_r, out_vld_nxt;
  lmss_pkg::result_t           out_res_r;
  lmss_pkg::result_t           res;

  always_comb begin
    s1_adv      = s1_vld_r && (!out_vld_r || !out_stall);
    in_stall    = s1_vld_r && !s1_adv;
    s1_vld_nxt  = (in_valid && !in_stall) || (s1_vld_r && !s1_adv);
    out_vld_nxt = s1_adv || (out_vld_r && out_stall);
  end

  lmss_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (s1_adv),
    .elapsed  (s1_elapsed_r),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_elapsed_r <= in_elapsed_cycles;
    end
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  always_comb begin
    out_valid       = out_vld_r;
    out_line        = out_res_r.line;
    out_lcd_mode    = out_res_r.mode;
    out_coincidence = out_res_r.match;
    out_vblank_irq  = out_res_r.pulse.vblank;
    out_stat_irq    = out_res_r.pulse.stat;
    out_draw_line   = out_res_r.pulse.draw;
  end

  `LMSS_ASSERT_NEXT(a_adv_lands_in_out, clk, rst_n, s1_adv, out_vld_r, "advanced item missing from output register")
  `LMSS_ASSERT_NEXT(a_held_item_kept, clk, rst_n, s1_vld_r && !s1_adv, s1_vld_r && $stable(s1_elapsed_r), "held input item lost")

endmodule

`default_nettype wire

[rtl/lmss_step.sv]
// ----------------------------------------------------------------------------
// lmss_step
// One conditional mode transition: retire the current mode if its duration
// has elapsed, advance mode and line, and collect interrupt pulses.
// ----------------------------------------------------------------------------
`default_nettype none

module lmss_step (
  input  wire lmss_pkg::cfg_t       cfg,
  input  wire lmss_pkg::lcd_state_t st_in,
  input  wire lmss_pkg::pulse_t     pul_in,
  output lmss_pkg::lcd_state_t      st_out,
  output lmss_pkg::pulse_t          pul_out
);

  logic [lmss_pkg::CNT_W-1:0]  dur;
  logic [lmss_pkg::LINE_W-1:0] line_inc;
  logic                        hit_inc;
  logic                        hit_zero;

  always_comb begin
    dur      = lmss_pkg::mode_dur(st_in.mode, cfg.dbl);
    line_inc = st_in.line + 8'd1;
    hit_inc  = (line_inc == cfg.compare);
    hit_zero = (cfg.compare == '0);
    st_out   = st_in;
    pul_out  = pul_in;
    if (st_in.count >= dur) begin
      st_out.count = st_in.count - dur;
      case (st_in.mode)
        lmss_pkg::MODE_HBLANK: begin
          st_out.line  = line_inc;
          st_out.match = hit_inc;
          if (hit_inc && cfg.irq_en[lmss_pkg::EN_MATCH_BIT]) begin
            pul_out.stat = 1'b1;
          end
          if (line_inc >= lmss_pkg::FIRST_BLANK_LINE) begin
            st_out.mode    = lmss_pkg::MODE_VBLANK;
            pul_out.vblank = 1'b1;
            if (cfg.irq_en[lmss_pkg::EN_VBLANK_BIT] || cfg.irq_en[lmss_pkg::EN_OAM_BIT]) begin
              pul_out.stat = 1'b1;
            end
          end else begin
            st_out.mode = lmss_pkg::MODE_OAM;
            if (cfg.irq_en[lmss_pkg::EN_OAM_BIT]) begin
              pul_out.stat = 1'b1;
            end
          end
        end
        lmss_pkg::MODE_VBLANK: begin
          if (st_in.line == '0) begin
            st_out.mode = lmss_pkg::MODE_OAM;
            if (cfg.irq_en[lmss_pkg::EN_OAM_BIT]) begin
              pul_out.stat = 1'b1;
            end
          end else begin
            st_out.line  = line_inc;
            st_out.match = hit_inc;
            if (hit_inc && cfg.irq_en[lmss_pkg::EN_MATCH_BIT]) begin
              pul_out.stat = 1'b1;
            end
            if (line_inc >= lmss_pkg::WRAP_LINE) begin
              st_out.line  = '0;
              st_out.match = hit_zero;
              if (hit_zero && cfg.irq_en[lmss_pkg::EN_MATCH_BIT]) begin
                pul_out.stat = 1'b1;
              end
            end
          end
        end
        lmss_pkg::MODE_OAM: begin
          st_out.mode = lmss_pkg::MODE_XFER;
        end
        lmss_pkg::MODE_XFER: begin
          st_out.mode  = lmss_pkg::MODE_HBLANK;
          pul_out.draw = 1'b1;
          if (cfg.irq_en[lmss_pkg::EN_HBLANK_BIT]) begin
            pul_out.stat = 1'b1;
          end
        end
        default: begin
          st_out.mode = lmss_pkg::MODE_HBLANK;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/lmss_seq.sv]
// ----------------------------------------------------------------------------
// lmss_seq
// Timing state, configuration registers and the chain of transition units
// that retires every mode boundary crossed by one item.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lmss_seq (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               step_en,
  input  wire [lmss_pkg::ELAP_W-1:0]        elapsed,
  input  wire                               cfg_we,
  input  wire [lmss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [lmss_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output lmss_pkg::result_t                 res
);

  logic [lmss_pkg::CNT_W-1:0]  count_r,  count_nxt;
  lmss_pkg::mode_t             mode_r,   mode_nxt;
  logic [lmss_pkg::LINE_W-1:0] line_r,   line_nxt;
  logic                        match_r,  match_nxt;
  logic                        enable_r;
  logic [lmss_pkg::CMP_W-1:0]  compare_r;
  logic [lmss_pkg::IRQ_W-1:0]  irq_en_r;
  logic                        dbl_r;

  lmss_pkg::cfg_t       cfg;
  lmss_pkg::lcd_state_t st_chain  [lmss_pkg::N_STEPS+1];
  lmss_pkg::pulse_t     pul_chain [lmss_pkg::N_STEPS+1];
  lmss_pkg::pulse_t     pul_fin;

  always_comb begin
    cfg.compare = compare_r;
    cfg.irq_en  = irq_en_r;
    cfg.dbl     = dbl_r;
    st_chain[0].count = count_r + lmss_pkg::CNT_W'(elapsed);
    st_chain[0].mode  = mode_r;
    st_chain[0].line  = line_r;
    st_chain[0].match = match_r;
    pul_chain[0]      = '0;
  end

  for (genvar g = 0; g < lmss_pkg::N_STEPS; g++) begin : g_step
    lmss_step u_step (
      .cfg    (cfg),
      .st_in  (st_chain[g]),
      .pul_in (pul_chain[g]),
      .st_out (st_chain[g+1]),
      .pul_out(pul_chain[g+1])
    );
  end

  always_comb begin
    count_nxt = count_r;
    mode_nxt  = mode_r;
    line_nxt  = line_r;
    match_nxt = match_r;
    pul_fin   = '0;
    if (step_en) begin
      if (enable_r) begin
        count_nxt = st_chain[lmss_pkg::N_STEPS].count;
        mode_nxt  = st_chain[lmss_pkg::N_STEPS].mode;
        line_nxt  = st_chain[lmss_pkg::N_STEPS].line;
        match_nxt = st_chain[lmss_pkg::N_STEPS].match;
        pul_fin   = pul_chain[lmss_pkg::N_STEPS];
      end else begin
        count_nxt = '0;
        mode_nxt  = lmss_pkg::MODE_HBLANK;
        line_nxt  = '0;
        match_nxt = 1'b0;
      end
    end else if (cfg_we && (cfg_index == lmss_pkg::CFG_LCD_ENABLE)) begin
      if (enable_r && !cfg_wdata[0]) begin
        line_nxt = '0;
        mode_nxt = lmss_pkg::MODE_HBLANK;
      end else if (!enable_r && cfg_wdata[0]) begin
        line_nxt  = '0;
        mode_nxt  = lmss_pkg::MODE_OAM;
        count_nxt = dbl_r ? lmss_pkg::CREDIT_DBL : lmss_pkg::CREDIT_SGL;
      end
    end
  end

  always_comb begin
    res.line  = line_nxt;
    res.mode  = mode_nxt;
    res.match = match_nxt;
    res.pulse = pul_fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      mode_r  <= lmss_pkg::MODE_OAM;
      line_r  <= '0;
      match_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      mode_r  <= mode_nxt;
      line_r  <= line_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b1;
      compare_r <= '0;
      irq_en_r  <= '0;
      dbl_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        lmss_pkg::CFG_LCD_ENABLE:   enable_r  <= cfg_wdata[0];
        lmss_pkg::CFG_LINE_COMPARE: compare_r <= cfg_wdata[lmss_pkg::CMP_W-1:0];
        lmss_pkg::CFG_IRQ_ENABLES:  irq_en_r  <= cfg_wdata[lmss_pkg::IRQ_W-1:0];
        lmss_pkg::CFG_DOUBLE_SPEED: dbl_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  `LMSS_ASSERT_NEXT(a_count_settled, clk, rst_n, step_en && enable_r, count_r < lmss_pkg::mode_dur(mode_r, 1'b1), "mode counter left above duration")
  `LMSS_ASSERT_NEXT(a_off_holds_line0, clk, rst_n, step_en && !enable_r, (line_r == '0) && (mode_r == lmss_pkg::MODE_HBLANK) && (count_r == '0), "display off did not hold line zero")
  `LMSS_ASSERT_NEXT(a_active_line_visible, clk, rst_n, step_en && enable_r, (mode_r == lmss_pkg::MODE_VBLANK) || (line_r < lmss_pkg::FIRST_BLANK_LINE), "active mode on a blank line")

endmodule

`default_nettype wire
